[design/pdf_pkg.sv]
package pdf_pkg;

   localparam int VALUE_W    = 32;
   localparam int CHAR_W     = 8;
   localparam int FW_W       = 5;
   localparam int SM_W       = 2;
   localparam int DIGITS     = 10;
   localparam int DIGIT_W    = 4;
   localparam int DIGIT_IX_W = 4;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_WIDTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGN_MODE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAD_ZEROS   = 2'd2;

   localparam logic [FW_W-1:0] FIELD_WIDTH_RST = 5'd5;
   localparam logic [SM_W-1:0] SIGN_MODE_RST   = 2'd0;
   localparam logic            PAD_ZEROS_RST   = 1'b1;

   typedef logic [VALUE_W-1:0]              value_type;
   typedef logic [CHAR_W-1:0]               char_type;
   typedef logic [DIGITS-1:0][DIGIT_W-1:0]  bcd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_PLAN,
      ST_SIGN,
      ST_PAD,
      ST_DIGIT
   } pdf_state_type;

   // One double-dabble step: correct every BCD digit that would overflow on
   // doubling, then shift the whole register left by one with a new low bit.
   function automatic bcd_type dabble_step(input bcd_type bcd, input logic new_bit);
      bcd_type adj;
      for (int i = 0; i < DIGITS; i++) begin
         adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
      end
      return bcd_type'({adj, new_bit});
   endfunction

endpackage

[design/pdf_ifs.sv]
interface pdf_req_if;
   import pdf_pkg::*;
   logic      valid;
   logic      ready;
   value_type value;
   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface pdf_rsp_if;
   import pdf_pkg::*;
   logic     valid;
   logic     ready;
   char_type text_char;
   logic     is_last;
   modport source (output valid, output text_char, output is_last, input ready);
   modport sink   (input valid, input text_char, input is_last, output ready);
endinterface

interface pdf_csr_if;
   import pdf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/padded_signed_decimal_formatter.sv]
// Channel   Dir   Handshake          Beat payload
// req_bus   in    valid / ready      value (signed 32 bits)
// rsp_bus   out   valid / ready      text_char (8 bits), is_last
// csr_bus   in    valid / ready      index (2 bits), data (5 bits); always ready
//
// A number is accepted, then converted one magnitude bit per cycle into the BCD
// register; then its digits are sized, the padding is planned and the sign slot is
// passed. The padding characters follow, then the digits.
// Reset is synchronous and active high; it restores the register defaults.
// A stalled rsp beat holds in the output register while the sequencer waits; a new
// number is taken once the last beat is registered.

module padded_signed_decimal_formatter #(
   parameter int MAX_FIELD_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   pdf_req_if.sink   req_bus,
   pdf_rsp_if.source rsp_bus,
   pdf_csr_if.sink   csr_bus
);
   import pdf_pkg::*;

   // Width of the padding arithmetic: wide enough for both the configured
   // width register and the saturation limit.
   localparam int LIM_W = $clog2(MAX_FIELD_WIDTH + 1);
   localparam int WW    = (LIM_W > FW_W) ? LIM_W : FW_W;

   // Configuration registers.
   logic [FW_W-1:0] field_width_ff, field_width_in;
   logic [SM_W-1:0] sign_mode_ff, sign_mode_in;
   logic            pad_zeros_ff, pad_zeros_in;

   // Sequencer and datapath.
   pdf_state_type         state_ff, state_in;
   logic                  neg_ff, neg_in;
   value_type             mag_ff, mag_in;
   bcd_type               bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIGIT_IX_W-1:0] ndig_ff, ndig_in;
   logic [WW-1:0]         pad_ff, pad_in;
   logic [DIGIT_IX_W-1:0] dig_ff, dig_in;

   // Output register that parts the sequencer from the consumer.
   logic     rsp_valid_ff, rsp_valid_in;
   char_type rsp_char_ff, rsp_char_in;
   logic     rsp_last_ff, rsp_last_in;

   logic     out_free;
   logic     need_sign;
   logic     conv_done;
   logic     emit;
   char_type emit_char;
   logic     emit_last;
   logic     accept;
   logic [WW-1:0] eff_width;
   logic [WW-1:0] ndig_ext;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign need_sign = sign_mode_ff[1] ? neg_ff : sign_mode_ff[0];
   assign conv_done = (cnt_ff == BIT_CNT_W'(VALUE_W - 1));
   assign accept    = req_bus.valid && req_bus.ready;

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.text_char = rsp_char_ff;
   assign rsp_bus.is_last   = rsp_last_ff;

   // Register writes; indexes beyond the list are ignored.
   always_comb begin
      field_width_in = field_width_ff;
      sign_mode_in   = sign_mode_ff;
      pad_zeros_in   = pad_zeros_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_FIELD_WIDTH: field_width_in = csr_bus.data[FW_W-1:0];
            CSR_SIGN_MODE:   sign_mode_in   = csr_bus.data[SM_W-1:0];
            CSR_PAD_ZEROS:   pad_zeros_in   = csr_bus.data[0];
            default: ;
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_bus.valid) state_in = ST_CONV;
         ST_CONV:  if (conv_done) state_in = ST_SIZE;
         ST_SIZE:  state_in = ST_PLAN;
         ST_PLAN:  state_in = ST_SIGN;
         ST_SIGN:  if (!need_sign || out_free) state_in = ST_PAD;
         ST_PAD:   if (pad_ff == '0) state_in = ST_DIGIT;
         ST_DIGIT: if (out_free && dig_ff == '0) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Character emission for the current state.
   always_comb begin
      emit      = 1'b0;
      emit_char = CHAR_SPACE;
      emit_last = 1'b0;
      unique case (state_ff)
         ST_SIGN: begin
            emit      = need_sign && out_free;
            emit_char = neg_ff ? CHAR_MINUS : CHAR_SPACE;
         end
         ST_PAD: begin
            emit      = (pad_ff != '0) && out_free;
            emit_char = pad_zeros_ff ? CHAR_ZERO : CHAR_SPACE;
         end
         ST_DIGIT: begin
            emit      = out_free;
            emit_char = CHAR_ZERO + char_type'(bcd_ff[dig_ff]);
            emit_last = (dig_ff == '0);
         end
         default: ;
      endcase
   end

   // Saturated field width and digit count on a common width.
   always_comb begin
      eff_width = (WW'(field_width_ff) > WW'(MAX_FIELD_WIDTH)) ?
                  WW'(MAX_FIELD_WIDTH) : WW'(field_width_ff);
      ndig_ext  = WW'(ndig_ff);
   end

   // Datapath.
   always_comb begin
      neg_in  = neg_ff;
      mag_in  = mag_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      ndig_in = ndig_ff;
      pad_in  = pad_ff;
      dig_in  = dig_ff;
      unique case (state_ff)
         ST_IDLE: begin
            // The negation of the most negative value wraps to 2^31, which
            // is exactly its magnitude when read as unsigned.
            neg_in = req_bus.value[VALUE_W-1];
            mag_in = req_bus.value[VALUE_W-1] ? value_type'(-req_bus.value)
                                              : req_bus.value;
            bcd_in = '0;
            cnt_in = '0;
         end
         ST_CONV: begin
            bcd_in = dabble_step(bcd_ff, mag_ff[VALUE_W-1]);
            mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
         end
         ST_SIZE: begin
            // Position of the highest nonzero digit; zero still prints one.
            ndig_in = DIGIT_IX_W'(1);
            for (int i = 1; i < DIGITS; i++) begin
               if (bcd_ff[i] != '0) ndig_in = DIGIT_IX_W'(i + 1);
            end
         end
         ST_PLAN: begin
            pad_in = (eff_width > ndig_ext) ? eff_width - ndig_ext : '0;
            dig_in = ndig_ff - 1'b1;
         end
         ST_PAD: if (emit) pad_in = pad_ff - 1'b1;
         ST_DIGIT: if (emit && dig_ff != '0) dig_in = dig_ff - 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_bus.ready);
      rsp_char_in  = emit ? emit_char : rsp_char_ff;
      rsp_last_in  = emit ? emit_last : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         field_width_ff <= FIELD_WIDTH_RST;
         sign_mode_ff   <= SIGN_MODE_RST;
         pad_zeros_ff   <= PAD_ZEROS_RST;
      end else begin
         state_ff       <= accept ? ST_CONV : state_in;
         rsp_valid_ff   <= rsp_valid_in;
         field_width_ff <= field_width_in;
         sign_mode_ff   <= sign_mode_in;
         pad_zeros_ff   <= pad_zeros_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      cnt_ff      <= cnt_in;
      ndig_ff     <= ndig_in;
      pad_ff      <= pad_in;
      dig_ff      <= dig_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

[design/pdf_checker.sv]
module pdf_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] text_char,
   input logic       is_last
);

   // A stalled beat keeps its character and end flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(text_char) && $stable(is_last))
      else $error("rsp beat changed while stalled");

   // Once a number is taken the block is busy converting it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again during conversion");

   // Only digits, minus and space are ever produced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (text_char >= 8'd48 && text_char <= 8'd57) ||
                    text_char == 8'd45 || text_char == 8'd32)
      else $error("unexpected character on rsp");

   // Out of reset the block is idle and has nothing to deliver.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

endmodule

bind padded_signed_decimal_formatter pdf_checker u_pdf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .text_char (rsp_bus.text_char),
   .is_last   (rsp_bus.is_last)
);
